@@ hw/rtl/cdsd_pkg.sv @@
`default_nettype none

package cdsd_pkg;

    // register stages from input beat to output beat
    localparam int NumStages = 7;

    typedef enum logic
    {
        OP_TO_SERIAL = 1'b0,
        OP_TO_CIVIL  = 1'b1
    } op_t;

    // pipeline control seen by the datapaths and the top level
    typedef struct packed
    {
        logic [NumStages-1:0] en;
        logic                 last_valid;
        op_t                  last_op;
    } pipe_ctrl_t;

    // reciprocal multipliers, ceil(2^k / d), exact for the dividend widths used
    localparam longint unsigned M400    = ((64'd1 << 26) + 64'd399) / 64'd400;
    localparam longint unsigned M146097 = ((64'd1 << 44) + 64'd146096) / 64'd146097;
    localparam longint unsigned M1460   = ((64'd1 << 29) + 64'd1459) / 64'd1460;
    localparam longint unsigned M365    = ((64'd1 << 27) + 64'd364) / 64'd365;
    localparam longint unsigned M153    = ((64'd1 << 19) + 64'd152) / 64'd153;

    // first day of each march-based month within the year
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            4'd12:   off = 9'd367;
            4'd13:   off = 9'd398;
            4'd14:   off = 9'd428;
            default: off = 9'd459;
        endcase
        return off;
    endfunction

    // year of era divided by 100, year of era below 400
    function automatic logic [1:0] div100(input logic [8:0] yoe);
        logic [1:0] q;
        if (yoe >= 9'd300)
        begin
            q = 2'd3;
        end
        else if (yoe >= 9'd200)
        begin
            q = 2'd2;
        end
        else if (yoe >= 9'd100)
        begin
            q = 2'd1;
        end
        else
        begin
            q = 2'd0;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cdsd_req_if.sv @@
`default_nettype none

interface cdsd_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] year;
    logic        [3:0]  month;
    logic        [4:0]  day;
    logic signed [24:0] serial_day;

    modport source (output valid, output op, output year, output month, output day,
                    output serial_day, input ready);
    modport sink   (input valid, input op, input year, input month, input day,
                    input serial_day, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cdsd_rsp_if.sv @@
`default_nettype none

interface cdsd_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] serial_day_out;
    logic signed [15:0] year_out;
    logic        [3:0]  month_out;
    logic        [4:0]  day_out;
    logic               range_error;

    modport source (output valid, output serial_day_out, output year_out, output month_out,
                    output day_out, output range_error, input ready);
    modport sink   (input valid, input serial_day_out, input year_out, input month_out,
                    input day_out, input range_error, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cdsd_pipe_ctrl.sv @@
`default_nettype none

module cdsd_pipe_ctrl
    import cdsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_op,
    input  wire logic       out_ready,
    output pipe_ctrl_t      ctrl,
    output logic            in_ready
);

    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] valid_next;
    logic [NumStages-1:0] op_reg;
    logic [NumStages-1:0] op_next;
    logic [NumStages-1:0] en;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[NumStages-1] = !valid_reg[NumStages-1] || out_ready;
        for (int i = NumStages - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    // valid and op travel with the data
    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        op_next[0]    = en[0] ? in_op    : op_reg[0];
        for (int i = 1; i < NumStages; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
            op_next[i]    = en[i] ? op_reg[i-1]    : op_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign ctrl.en         = en;
    assign ctrl.last_valid = valid_reg[NumStages-1];
    assign ctrl.last_op    = op_t'(op_reg[NumStages-1]);
    assign in_ready        = en[0];

endmodule

`default_nettype wire

@@ hw/rtl/cdsd_to_serial.sv @@
`default_nettype none

module cdsd_to_serial
    import cdsd_pkg::*;
(
    input  wire logic               clk,
    input  wire pipe_ctrl_t         ctrl,
    input  wire logic signed [15:0] year,
    input  wire logic        [3:0]  month,
    input  wire logic        [4:0]  day,
    output logic             [24:0] serial_day_out
);

    // stage 0: march-based year and day of year, offset to non-negative, reciprocal of 400
    logic        [3:0]  mp;
    logic signed [16:0] yadj;
    logic        [16:0] u_next;
    logic        [34:0] prod400;
    logic        [7:0]  q0_next;
    logic        [9:0]  doy0_next;
    logic        [16:0] u0_reg;
    logic        [7:0]  q0_reg;
    logic        [9:0]  doy0_reg;

    always_comb
    begin
        if (month <= 4'd2)
        begin
            mp   = month + 4'd9;
            yadj = 17'(year) - 17'sd1;
        end
        else
        begin
            mp   = month - 4'd3;
            yadj = 17'(year);
        end
        u_next    = 17'(yadj + 17'sd32800);
        prod400   = 35'(u_next) * 35'(M400);
        q0_next   = prod400[33:26];
        doy0_next = 10'(month_offset(mp)) + 10'(day) - 10'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            u0_reg   <= u_next;
            q0_reg   <= q0_next;
            doy0_reg <= doy0_next;
        end
    end

    // stage 1: year of era
    logic [8:0] yoe1_next;
    logic [8:0] yoe1_reg;
    logic [7:0] q1_reg;
    logic [9:0] doy1_reg;

    assign yoe1_next = 9'(u0_reg - 17'(q0_reg) * 17'd400);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            yoe1_reg <= yoe1_next;
            q1_reg   <= q0_reg;
            doy1_reg <= doy0_reg;
        end
    end

    // stage 2: day of era and era start in days
    logic        [17:0] base;
    logic        [18:0] doe2_next;
    logic signed [8:0]  era;
    logic        [25:0] eday2_next;
    logic        [18:0] doe2_reg;
    logic        [25:0] eday2_reg;

    always_comb
    begin
        base       = 18'(yoe1_reg) * 18'd365 + 18'(yoe1_reg >> 2) - 18'(div100(yoe1_reg));
        doe2_next  = {1'b0, base} + {{9{doy1_reg[9]}}, doy1_reg};
        era        = $signed({1'b0, q1_reg}) - 9'sd82;
        eday2_next = 26'(26'(era) * 26'sd146097);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            doe2_reg  <= doe2_next;
            eday2_reg <= eday2_next;
        end
    end

    // stage 3: shift to the 1970 epoch
    logic [24:0] res3_next;
    logic [24:0] res3_reg;
    logic [24:0] res4_reg;
    logic [24:0] res5_reg;
    logic [24:0] res6_reg;

    assign res3_next = 25'(eday2_reg) + {{6{doe2_reg[18]}}, doe2_reg} - 25'd719468;

    // stages 3 to 6: result waits for the civil path depth
    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            res3_reg <= res3_next;
        end
        if (ctrl.en[4])
        begin
            res4_reg <= res3_reg;
        end
        if (ctrl.en[5])
        begin
            res5_reg <= res4_reg;
        end
        if (ctrl.en[6])
        begin
            res6_reg <= res5_reg;
        end
    end

    assign serial_day_out = res6_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cdsd_to_civil.sv @@
`default_nettype none

module cdsd_to_civil
    import cdsd_pkg::*;
(
    input  wire logic               clk,
    input  wire pipe_ctrl_t         ctrl,
    input  wire logic signed [24:0] serial_day,
    output logic             [15:0] year_out,
    output logic             [3:0]  month_out,
    output logic             [4:0]  day_out,
    output logic                    range_error
);

    localparam logic [17:0] DoeLast = 18'd146096;

    // day of era divided by 36524, day of era below 146097
    function automatic logic [2:0] div36524(input logic [17:0] doe);
        logic [2:0] q;
        if (doe >= 18'd146096)
        begin
            q = 3'd4;
        end
        else if (doe >= 18'd109572)
        begin
            q = 3'd3;
        end
        else if (doe >= 18'd73048)
        begin
            q = 3'd2;
        end
        else if (doe >= 18'd36524)
        begin
            q = 3'd1;
        end
        else
        begin
            q = 3'd0;
        end
        return q;
    endfunction

    // stage 0: epoch shift plus era offset, reciprocal of the era length
    logic [25:0] w_next;
    logic [52:0] prod_era;
    logic [7:0]  q0_next;
    logic [25:0] w0_reg;
    logic [7:0]  q0_reg;

    always_comb
    begin
        w_next   = 26'(serial_day) + 26'd16790138;
        prod_era = 53'(w_next) * 53'(M146097);
        q0_next  = prod_era[51:44];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            w0_reg <= w_next;
            q0_reg <= q0_next;
        end
    end

    // stage 1: day of era
    logic [17:0] doe1_next;
    logic [17:0] doe1_reg;
    logic [7:0]  q1_reg;

    assign doe1_next = 18'(w0_reg - 26'(q0_reg) * 26'd146097);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            doe1_reg <= doe1_next;
            q1_reg   <= q0_reg;
        end
    end

    // stage 2: remove leap days from day of era
    logic [36:0] prod1460;
    logic [17:0] t2_next;
    logic [17:0] t2_reg;
    logic [17:0] doe2_reg;
    logic [7:0]  q2_reg;

    always_comb
    begin
        prod1460 = 37'(doe1_reg) * 37'(M1460);
        t2_next  = doe1_reg - 18'(prod1460[35:29]) + 18'(div36524(doe1_reg))
                   - 18'(doe1_reg == DoeLast);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            t2_reg   <= t2_next;
            doe2_reg <= doe1_reg;
            q2_reg   <= q1_reg;
        end
    end

    // stage 3: year of era
    logic [36:0] prod365;
    logic [8:0]  yoe3_next;
    logic [8:0]  yoe3_reg;
    logic [17:0] doe3_reg;
    logic [7:0]  q3_reg;

    always_comb
    begin
        prod365   = 37'(t2_reg) * 37'(M365);
        yoe3_next = prod365[35:27];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            yoe3_reg <= yoe3_next;
            doe3_reg <= doe2_reg;
            q3_reg   <= q2_reg;
        end
    end

    // stage 4: day of march-based year
    logic [17:0] base;
    logic [8:0]  doy4_next;
    logic [8:0]  doy4_reg;
    logic [8:0]  yoe4_reg;
    logic [7:0]  q4_reg;

    always_comb
    begin
        base      = 18'(yoe3_reg) * 18'd365 + 18'(yoe3_reg >> 2) - 18'(div100(yoe3_reg));
        doy4_next = 9'(doe3_reg - base);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            doy4_reg <= doy4_next;
            yoe4_reg <= yoe3_reg;
            q4_reg   <= q3_reg;
        end
    end

    // stage 5: march-based month
    logic [10:0] x153;
    logic [22:0] prod153;
    logic [3:0]  mp5_next;
    logic [3:0]  mp5_reg;
    logic [8:0]  doy5_reg;
    logic [8:0]  yoe5_reg;
    logic [7:0]  q5_reg;

    always_comb
    begin
        x153     = 11'(doy4_reg) * 11'd5 + 11'd2;
        prod153  = 23'(x153) * 23'(M153);
        mp5_next = prod153[22:19];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[5])
        begin
            mp5_reg  <= mp5_next;
            doy5_reg <= doy4_reg;
            yoe5_reg <= yoe4_reg;
            q5_reg   <= q4_reg;
        end
    end

    // stage 6: civil month, day and clamped year
    logic        [3:0]  month_next;
    logic        [4:0]  day_next;
    logic signed [17:0] era;
    logic signed [17:0] yr_full;
    logic        [15:0] year_next;
    logic               err_next;
    logic        [15:0] year_reg;
    logic        [3:0]  month_reg;
    logic        [4:0]  day_reg;
    logic               err_reg;

    always_comb
    begin
        day_next = 5'(doy5_reg - month_offset(mp5_reg) + 9'd1);
        if (mp5_reg < 4'd10)
        begin
            month_next = mp5_reg + 4'd3;
        end
        else
        begin
            month_next = mp5_reg - 4'd9;
        end
        era     = $signed({10'd0, q5_reg}) - 18'sd110;
        yr_full = era * 18'sd400 + $signed({9'd0, yoe5_reg})
                  + $signed({17'd0, (month_next <= 4'd2)});
        if (yr_full > 18'sd32767)
        begin
            year_next = 16'h7fff;
            err_next  = 1'b1;
        end
        else if (yr_full < -18'sd32768)
        begin
            year_next = 16'h8000;
            err_next  = 1'b1;
        end
        else
        begin
            year_next = 16'(yr_full);
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[6])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            err_reg   <= err_next;
        end
    end

    assign year_out    = year_reg;
    assign month_out   = month_reg;
    assign day_out     = day_reg;
    assign range_error = err_reg;

endmodule

`default_nettype wire

@@ hw/rtl/civil_date_serial_day_converter.sv @@
// throughput: one conversion per cycle, set by the 7-stage pipeline with one
//   beat per stage; a stalled response holds only the stages behind it
// reset: rst_n clears the stage valid bits only, no clearing pass
`default_nettype none

module civil_date_serial_day_converter
    import cdsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cdsd_req_if.sink    req,
    cdsd_rsp_if.source  rsp
);

    pipe_ctrl_t  ctrl;
    logic        in_ready;
    logic [24:0] ser_day;
    logic [15:0] civ_year;
    logic [3:0]  civ_month;
    logic [4:0]  civ_day;
    logic        civ_err;

    // valid bits and stage enables
    cdsd_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_op     (req.op),
        .out_ready (rsp.ready),
        .ctrl      (ctrl),
        .in_ready  (in_ready)
    );

    // civil date to day count
    cdsd_to_serial u_to_serial
    (
        .clk            (clk),
        .ctrl           (ctrl),
        .year           (req.year),
        .month          (req.month),
        .day            (req.day),
        .serial_day_out (ser_day)
    );

    // day count to civil date
    cdsd_to_civil u_to_civil
    (
        .clk         (clk),
        .ctrl        (ctrl),
        .serial_day  (req.serial_day),
        .year_out    (civ_year),
        .month_out   (civ_month),
        .day_out     (civ_day),
        .range_error (civ_err)
    );

    assign req.ready = in_ready;
    assign rsp.valid = ctrl.last_valid;

    // fields of the other operation read as zero
    always_comb
    begin
        if (ctrl.last_op == OP_TO_SERIAL)
        begin
            rsp.serial_day_out = ser_day;
            rsp.year_out       = '0;
            rsp.month_out      = '0;
            rsp.day_out        = '0;
            rsp.range_error    = 1'b0;
        end
        else
        begin
            rsp.serial_day_out = '0;
            rsp.year_out       = civ_year;
            rsp.month_out      = civ_month;
            rsp.day_out        = civ_day;
            rsp.range_error    = civ_err;
        end
    end

endmodule

`default_nettype wire
